// ===== hdl/per_thread_shadow_stack_checker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-thread shadow stack checker
// Concurrent assertion shorthands, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PER_THREAD_SHADOW_STACK_CHECKER_MACROS_SVH
`define PER_THREAD_SHADOW_STACK_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Shadow stack checker package
// Sizes, status codes, control structs and result packing shared by the block.
// ----------------------------------------------------------------------------
package pssc_pkg;

  localparam int THREADS = 8;
  localparam int DEPTH   = 512;

  localparam int SLOT_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int TCNT_W = $clog2(THREADS + 1);
  localparam int DPTR_W = $clog2(DEPTH);
  localparam int DCNT_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = SLOT_W + DPTR_W;

  localparam int TID_W  = 16;
  localparam int ADR_W  = 64;
  localparam int FRAME_W = 2 * ADR_W;
  localparam int IN_W   = TID_W + 2 * ADR_W;

  localparam int STATUS_W       = 3;
  localparam int SLOT_FIELD_W   = 3;
  localparam int DEPTH_FIELD_W  = 10;
  localparam int OUT_W          = STATUS_W + SLOT_FIELD_W + DEPTH_FIELD_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_THREADS   = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic {
    OP_ENTRY = 1'b0,
    OP_EXIT  = 1'b1
  } op_t;

  typedef struct packed {
    logic load;
    logic lookup_commit;
    logic rd_en;
    logic check_commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_status_t;

  function automatic logic [OUT_W-1:0] pack_result(
    input status_t                  status,
    input logic [SLOT_FIELD_W-1:0]  slot,
    input logic [DEPTH_FIELD_W-1:0] depth
  );
    pack_result = {depth, slot, status};
  endfunction

endpackage

// ===== hdl/per_thread_shadow_stack_checker.sv =====
// ----------------------------------------------------------------------------
// Per-thread shadow stack checker
// An entry, an underflow or a full table is resolved in the lookup state; an exit on a
// non-empty stack also reads the stack and is resolved in the check state.
// One request is in flight at a time; a waiting result does not block accept.
// Synchronous active-low reset empties the thread table; memories are not cleared.
// ----------------------------------------------------------------------------
module per_thread_shadow_stack_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pssc_pkg::IN_W-1:0]   in_tdata,   // thread_id, func_addr, return_addr
  input  logic [0:0]                  in_tuser,   // op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pssc_pkg::OUT_W-1:0]  out_tdata   // status, slot, stack_depth
);

  pssc_pkg::ctl_cmd_t   cmd;
  pssc_pkg::dp_status_t sts;

  pssc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pssc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hdl/pssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Shadow stack checker controller
// Sequences accept, table lookup, stack read and result hand-off.
// ----------------------------------------------------------------------------
module pssc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  pssc_pkg::dp_status_t  sts,
  output pssc_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.need_read) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHECK;
        end else if (out_free) begin
          cmd.lookup_commit = 1'b1;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          cmd.check_commit = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/pssc_dp.sv =====
// ----------------------------------------------------------------------------
// Shadow stack checker datapath
// Thread table, per-thread frame counts, frame memory and result register.
// ----------------------------------------------------------------------------
module pssc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [0:0]                  in_tuser,
  input  logic [pssc_pkg::IN_W-1:0]   in_tdata,
  output logic [pssc_pkg::OUT_W-1:0]  out_tdata,
  input  pssc_pkg::ctl_cmd_t          cmd,
  output pssc_pkg::dp_status_t        sts
);

  logic                              op_r;
  logic [pssc_pkg::TID_W-1:0]        tid_r;
  logic [pssc_pkg::FRAME_W-1:0]      frame_r;

  logic [pssc_pkg::TID_W-1:0]        ids_r    [pssc_pkg::THREADS];
  logic [pssc_pkg::DCNT_W-1:0]       counts_r [pssc_pkg::THREADS];
  logic [pssc_pkg::TCNT_W-1:0]       threads_used_r;

  logic [pssc_pkg::FRAME_W-1:0]      mem [2**pssc_pkg::ADDR_W];
  logic [pssc_pkg::FRAME_W-1:0]      rd_data_r;
  logic [pssc_pkg::SLOT_W-1:0]       slot_r;
  logic [pssc_pkg::DCNT_W-1:0]       depth_r;
  logic [pssc_pkg::OUT_W-1:0]        out_tdata_r;

  logic [pssc_pkg::THREADS-1:0]      hit;
  logic [pssc_pkg::SLOT_W-1:0]       enc;
  logic                              found;
  logic                              tbl_full;
  logic                              thr_err;
  logic [pssc_pkg::SLOT_W-1:0]       slot_lk;
  logic [pssc_pkg::DCNT_W-1:0]       depth_lk;
  logic [pssc_pkg::DCNT_W-1:0]       depth_inc;
  logic [pssc_pkg::DCNT_W-1:0]       depth_dec_lk;
  logic [pssc_pkg::DCNT_W-1:0]       depth_dec_r;
  logic                              push_ok;
  logic [pssc_pkg::OUT_W-1:0]        lk_result;
  logic [pssc_pkg::OUT_W-1:0]        ck_result;
  logic                              frame_match;

  always_comb begin
    hit = '0;
    enc = '0;
    for (int i = 0; i < pssc_pkg::THREADS; i++) begin
      hit[i] = (pssc_pkg::TCNT_W'(i) < threads_used_r) && (ids_r[i] == tid_r);
    end
    for (int i = 0; i < pssc_pkg::THREADS; i++) begin
      if (hit[i]) begin
        enc = pssc_pkg::SLOT_W'(i);
      end
    end
  end

  assign found        = |hit;
  assign tbl_full     = (threads_used_r == pssc_pkg::TCNT_W'(pssc_pkg::THREADS));
  assign thr_err      = !found && tbl_full;
  assign slot_lk      = found ? enc : threads_used_r[pssc_pkg::SLOT_W-1:0];
  assign depth_lk     = found ? counts_r[enc] : '0;
  assign depth_inc    = depth_lk + pssc_pkg::DCNT_W'(1);
  assign depth_dec_lk = depth_lk - pssc_pkg::DCNT_W'(1);
  assign depth_dec_r  = depth_r - pssc_pkg::DCNT_W'(1);
  assign push_ok      = !thr_err && (op_r == pssc_pkg::OP_ENTRY)
                        && (depth_lk != pssc_pkg::DCNT_W'(pssc_pkg::DEPTH));

  assign sts.need_read = !thr_err && (op_r == pssc_pkg::OP_EXIT)
                         && (depth_lk != '0);

  always_comb begin
    priority if (thr_err) begin
      lk_result = pssc_pkg::pack_result(pssc_pkg::ST_THREADS, '0, '0);
    end else if (op_r == pssc_pkg::OP_ENTRY && !push_ok) begin
      lk_result = pssc_pkg::pack_result(pssc_pkg::ST_OVERFLOW,
                    pssc_pkg::SLOT_FIELD_W'(slot_lk),
                    pssc_pkg::DEPTH_FIELD_W'(depth_lk));
    end else if (op_r == pssc_pkg::OP_ENTRY) begin
      lk_result = pssc_pkg::pack_result(pssc_pkg::ST_OK,
                    pssc_pkg::SLOT_FIELD_W'(slot_lk),
                    pssc_pkg::DEPTH_FIELD_W'(depth_inc));
    end else begin
      lk_result = pssc_pkg::pack_result(pssc_pkg::ST_UNDERFLOW,
                    pssc_pkg::SLOT_FIELD_W'(slot_lk), '0);
    end
  end

  assign frame_match = (rd_data_r == frame_r);

  always_comb begin
    if (frame_match) begin
      ck_result = pssc_pkg::pack_result(pssc_pkg::ST_OK,
                    pssc_pkg::SLOT_FIELD_W'(slot_r),
                    pssc_pkg::DEPTH_FIELD_W'(depth_dec_r));
    end else begin
      ck_result = pssc_pkg::pack_result(pssc_pkg::ST_MISMATCH,
                    pssc_pkg::SLOT_FIELD_W'(slot_r),
                    pssc_pkg::DEPTH_FIELD_W'(depth_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser[0];
      tid_r   <= in_tdata[pssc_pkg::TID_W-1:0];
      frame_r <= in_tdata[pssc_pkg::IN_W-1:pssc_pkg::TID_W];
    end
    if (cmd.rd_en) begin
      slot_r  <= slot_lk;
      depth_r <= depth_lk;
    end
    if (cmd.lookup_commit) begin
      out_tdata_r <= lk_result;
    end else if (cmd.check_commit) begin
      out_tdata_r <= ck_result;
    end
    if (cmd.lookup_commit && push_ok) begin
      counts_r[slot_lk] <= depth_inc;
      if (!found) begin
        ids_r[slot_lk] <= tid_r;
      end
    end else if (cmd.check_commit && frame_match) begin
      counts_r[slot_r] <= depth_dec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threads_used_r <= '0;
    end else if (cmd.lookup_commit && push_ok && !found) begin
      threads_used_r <= threads_used_r + pssc_pkg::TCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_commit && push_ok) begin
      mem[{slot_lk, depth_lk[pssc_pkg::DPTR_W-1:0]}] <= frame_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[{slot_lk, depth_dec_lk[pssc_pkg::DPTR_W-1:0]}];
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

// ===== hdl/pssc_checker.sv =====
// ----------------------------------------------------------------------------
// Shadow stack checker port assertions
// Checks handshake behavior and result field consistency at the top level.
// ----------------------------------------------------------------------------
`include "per_thread_shadow_stack_checker_macros.svh"

module pssc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pssc_pkg::OUT_W-1:0]  out_tdata
);

  `PSSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PSSC_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second request taken while busy")
  `PSSC_ASSERT_SAME(a_status_range, out_tvalid, out_tdata[2:0] <= pssc_pkg::ST_UNDERFLOW, "bad status code")
  `PSSC_ASSERT_SAME(a_table_full, out_tvalid && out_tdata[2:0] == pssc_pkg::ST_THREADS, out_tdata[15:3] == '0, "table full result not zeroed")
  `PSSC_ASSERT_SAME(a_underflow, out_tvalid && out_tdata[2:0] == pssc_pkg::ST_UNDERFLOW, out_tdata[15:6] == '0, "underflow with nonzero depth")

endmodule

bind per_thread_shadow_stack_checker pssc_checker u_pssc_checker (.*);

// ===== bench/per_thread_shadow_stack_checker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-thread shadow stack checker testbench
// Sends function entry and exit requests over the input stream and checks
// every result against a predictor that tracks the thread table and each
// thread's stack of call frames. Covers the field extremes, underflow,
// corruption on exit, stack overflow and a full thread table, then runs
// well-formed call and return traffic with random corruption under changing
// idle patterns and a long receiver stall.
// ----------------------------------------------------------------------------
module per_thread_shadow_stack_checker_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct packed {
    pssc_pkg::status_t                  status;
    logic [pssc_pkg::SLOT_FIELD_W-1:0]  slot;
    logic [pssc_pkg::DEPTH_FIELD_W-1:0] depth;
  } frame_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [pssc_pkg::IN_W-1:0]   in_tdata;
  logic [0:0]                  in_tuser;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [pssc_pkg::OUT_W-1:0]  out_tdata;

  logic [pssc_pkg::TID_W-1:0]  tbl_ids [pssc_pkg::THREADS];
  int                          tbl_used;
  int                          frame_depth [pssc_pkg::THREADS];
  logic [pssc_pkg::ADR_W-1:0]  frame_func [pssc_pkg::THREADS][pssc_pkg::DEPTH];
  logic [pssc_pkg::ADR_W-1:0]  frame_ret [pssc_pkg::THREADS][pssc_pkg::DEPTH];

  frame_result_t     pending_results[$];
  frame_result_t     oldest;
  int                error_count;
  int                cycle_count;
  int                request_count;
  int                status_count [5];
  int                send_idle_pct;
  int                recv_idle_pct;
  int                stall_cycles;

  per_thread_shadow_stack_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_slot(input logic [pssc_pkg::TID_W-1:0] tid);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_ids[i] == tid) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic frame_result_t track_call(input pssc_pkg::op_t op,
                                               input logic [pssc_pkg::TID_W-1:0] tid,
                                               input logic [pssc_pkg::ADR_W-1:0] fn,
                                               input logic [pssc_pkg::ADR_W-1:0] cs);
    frame_result_t r;
    int s;
    int d;
    bit fresh;
    fresh = 1'b0;
    s = find_slot(tid);
    r.status = pssc_pkg::ST_OK;
    r.slot = '0;
    r.depth = '0;
    if (s < 0) begin
      if (tbl_used >= pssc_pkg::THREADS) begin
        r.status = pssc_pkg::ST_THREADS;
        return r;
      end
      s = tbl_used;
      fresh = 1'b1;
    end
    d = fresh ? 0 : frame_depth[s];
    r.slot = s[pssc_pkg::SLOT_FIELD_W-1:0];
    if (op == pssc_pkg::OP_ENTRY) begin
      if (d >= pssc_pkg::DEPTH) begin
        r.status = pssc_pkg::ST_OVERFLOW;
        r.depth = d[pssc_pkg::DEPTH_FIELD_W-1:0];
        return r;
      end
      if (fresh) begin
        tbl_ids[s] = tid;
        tbl_used = s + 1;
      end
      frame_func[s][d] = fn;
      frame_ret[s][d] = cs;
      d++;
    end else begin
      if (d == 0) begin
        r.status = pssc_pkg::ST_UNDERFLOW;
        return r;
      end
      if (frame_func[s][d-1] != fn || frame_ret[s][d-1] != cs) begin
        r.status = pssc_pkg::ST_MISMATCH;
        r.depth = d[pssc_pkg::DEPTH_FIELD_W-1:0];
        return r;
      end
      d--;
    end
    frame_depth[s] = d;
    r.depth = d[pssc_pkg::DEPTH_FIELD_W-1:0];
    return r;
  endfunction

  function automatic logic [pssc_pkg::ADR_W-1:0] rand_addr();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return '0;
    end else if (pick < 10) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [pssc_pkg::TID_W-1:0] unknown_tid();
    logic [pssc_pkg::TID_W-1:0] tid;
    tid = pssc_pkg::TID_W'($urandom_range(16'hFFFF));
    while (find_slot(tid) >= 0) begin
      tid = pssc_pkg::TID_W'($urandom_range(16'hFFFF));
    end
    return tid;
  endfunction

  task automatic send_request(input pssc_pkg::op_t op,
                              input logic [pssc_pkg::TID_W-1:0] tid,
                              input logic [pssc_pkg::ADR_W-1:0] fn,
                              input logic [pssc_pkg::ADR_W-1:0] cs);
    frame_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {cs, fn, tid};
    in_tuser <= op;
    do begin
      @(posedge clk);
    end while (!in_tready);
    r = track_call(op, tid, fn, cs);
    pending_results.push_back(r);
    status_count[int'(r.status)]++;
    request_count++;
  endtask

  task automatic test_directed_basics();
    logic [pssc_pkg::TID_W-1:0] ta;
    logic [pssc_pkg::TID_W-1:0] tb;
    logic [pssc_pkg::TID_W-1:0] tc;
    ta = 16'h0000;
    tb = 16'hFFFF;
    tc = 16'h5AC3;
    send_request(pssc_pkg::OP_ENTRY, ta, 64'h0, 64'h0);
    send_request(pssc_pkg::OP_ENTRY, tb, '1, '1);
    send_request(pssc_pkg::OP_EXIT, tc, 64'h1234, 64'h5678);
    send_request(pssc_pkg::OP_ENTRY, tb, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(pssc_pkg::OP_EXIT, tb, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(pssc_pkg::OP_EXIT, tb, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(pssc_pkg::OP_EXIT, tb, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(pssc_pkg::OP_EXIT, tb, '1, '1);
    send_request(pssc_pkg::OP_EXIT, tb, '1, '1);
    send_request(pssc_pkg::OP_ENTRY, tc, 64'hA5A5_5A5A_0F0F_F0F0, 64'h3C3C_C3C3_6969_9696);
    send_request(pssc_pkg::OP_EXIT, ta, 64'h0, 64'h0);
    send_request(pssc_pkg::OP_EXIT, tc, 64'hA5A5_5A5A_0F0F_F0F0, 64'h3C3C_C3C3_6969_9696);
  endtask

  task automatic test_thread_table_full();
    while (tbl_used < pssc_pkg::THREADS) begin
      send_request(pssc_pkg::OP_ENTRY, unknown_tid(), rand_addr(), rand_addr());
    end
    send_request(pssc_pkg::OP_ENTRY, unknown_tid(), rand_addr(), rand_addr());
    send_request(pssc_pkg::OP_EXIT, unknown_tid(), rand_addr(), rand_addr());
  endtask

  task automatic test_stack_overflow();
    logic [pssc_pkg::TID_W-1:0] tid;
    int d;
    tid = tbl_ids[0];
    while (frame_depth[0] < pssc_pkg::DEPTH) begin
      send_request(pssc_pkg::OP_ENTRY, tid, rand_addr(), rand_addr());
    end
    send_request(pssc_pkg::OP_ENTRY, tid, rand_addr(), rand_addr());
    send_request(pssc_pkg::OP_EXIT, tid, ~frame_func[0][pssc_pkg::DEPTH-1],
                 frame_ret[0][pssc_pkg::DEPTH-1]);
    while (frame_depth[0] > pssc_pkg::DEPTH - 8) begin
      d = frame_depth[0];
      send_request(pssc_pkg::OP_EXIT, tid, frame_func[0][d-1], frame_ret[0][d-1]);
    end
  endtask

  task automatic test_random_calls(input int count, input int send_pct, input int recv_pct);
    pssc_pkg::op_t op;
    logic [pssc_pkg::TID_W-1:0] tid;
    logic [pssc_pkg::ADR_W-1:0] fn;
    logic [pssc_pkg::ADR_W-1:0] cs;
    int s;
    int d;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      fn = rand_addr();
      cs = rand_addr();
      if ($urandom_range(99) < 4) begin
        tid = unknown_tid();
        op = pssc_pkg::op_t'($urandom_range(1));
      end else begin
        s = $urandom_range(tbl_used - 1);
        tid = tbl_ids[s];
        d = frame_depth[s];
        pick = $urandom_range(99);
        if (d == 0) begin
          op = (pick < 8) ? pssc_pkg::OP_EXIT : pssc_pkg::OP_ENTRY;
        end else if (d < 24) begin
          op = (pick < 55) ? pssc_pkg::OP_ENTRY : pssc_pkg::OP_EXIT;
        end else begin
          op = (pick < 25) ? pssc_pkg::OP_ENTRY : pssc_pkg::OP_EXIT;
        end
        if (op == pssc_pkg::OP_EXIT && d > 0) begin
          fn = frame_func[s][d-1];
          cs = frame_ret[s][d-1];
          pick = $urandom_range(99);
          if (pick < 6) begin
            fn[$urandom_range(pssc_pkg::ADR_W-1)] ^= 1'b1;
          end else if (pick < 12) begin
            cs[$urandom_range(pssc_pkg::ADR_W-1)] ^= 1'b1;
          end else if (pick < 15) begin
            fn = rand_addr();
            cs = rand_addr();
          end
        end
      end
      send_request(op, tid, fn, cs);
    end
  endtask

  task automatic test_output_backpressure();
    stall_cycles = HOLDOFF_CYCLES;
    test_random_calls(40, 0, 0);
  endtask

  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata[pssc_pkg::STATUS_W-1:0] != oldest.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, oldest.status,
                   out_tdata[pssc_pkg::STATUS_W-1:0]);
          error_count++;
        end
        if (out_tdata[pssc_pkg::STATUS_W +: pssc_pkg::SLOT_FIELD_W] != oldest.slot) begin
          $display("%0t: slot expected %0d, actual %0d", $time, oldest.slot,
                   out_tdata[pssc_pkg::STATUS_W +: pssc_pkg::SLOT_FIELD_W]);
          error_count++;
        end
        if (out_tdata[pssc_pkg::STATUS_W+pssc_pkg::SLOT_FIELD_W +: pssc_pkg::DEPTH_FIELD_W]
            != oldest.depth) begin
          $display("%0t: stack_depth expected %0d, actual %0d", $time, oldest.depth,
                   out_tdata[pssc_pkg::STATUS_W+pssc_pkg::SLOT_FIELD_W +:
                             pssc_pkg::DEPTH_FIELD_W]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    tbl_used = 0;
    error_count = 0;
    cycle_count = 0;
    request_count = 0;
    stall_cycles = 0;
    send_idle_pct = 35;
    recv_idle_pct = 56;
    foreach (status_count[i]) begin
      status_count[i] = 0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_thread_table_full();
    test_random_calls(240, 35, 56);
    test_random_calls(240, 56, 35);
    test_output_backpressure();
    test_stack_overflow();
    test_random_calls(240, 0, 0);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d requests: %0d ok, %0d corrupt, %0d overflow, %0d table full, %0d underflow.",
             request_count, status_count[0], status_count[1], status_count[2],
             status_count[3], status_count[4]);
    $display("Idle patterns 35/56, 56/35 and none, plus a %0d-cycle receiver stall.",
             HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
